FILE: hw/rtl/lcdns_pkg.sv
// Package for the character LCD nibble sequencer: operation codes, register
// indexes, the control word layout and the microprogram ROM.
// Depends on nothing; used by char_lcd_nibble_sequencer and lcdns_checker.
`default_nettype none

package lcdns_pkg;

   // Operation codes carried in req_func.
   localparam logic [1:0] FUNC_INIT       = 2'd0;
   localparam logic [1:0] FUNC_DATA       = 2'd1;
   localparam logic [1:0] FUNC_COMMAND    = 2'd2;
   localparam logic [1:0] FUNC_SET_CURSOR = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_POWER_UP_WAIT  = 2'd0;
   localparam logic [1:0] CSR_INIT_STEP_WAIT = 2'd1;
   localparam logic [1:0] CSR_COMMAND_WAIT   = 2'd2;

   localparam logic [7:0] POWER_UP_WAIT_RESET  = 8'd110;
   localparam logic [7:0] INIT_STEP_WAIT_RESET = 8'd10;
   localparam logic [7:0] COMMAND_WAIT_RESET   = 8'd2;

   localparam int COLUMNS_DEFAULT = 16;
   // The recorded column is four bits wide.
   localparam int COL_FIELD_LIMIT = 16;

   // Nibble source.
   localparam logic [1:0] NIB_CONST = 2'd0;
   localparam logic [1:0] NIB_HIGH  = 2'd1;
   localparam logic [1:0] NIB_LOW   = 2'd2;

   // Wait source.
   localparam logic [1:0] WAIT_NONE    = 2'd0;
   localparam logic [1:0] WAIT_POWER   = 2'd1;
   localparam logic [1:0] WAIT_INIT    = 2'd2;
   localparam logic [1:0] WAIT_COMMAND = 2'd3;

   // End-of-program condition.
   localparam logic [2:0] DONE_NEVER     = 3'd0;
   localparam logic [2:0] DONE_ALWAYS    = 3'd1;
   localparam logic [2:0] DONE_ROW0_COL0 = 3'd2;
   localparam logic [2:0] DONE_COL0      = 3'd3;
   localparam logic [2:0] DONE_CNT1      = 3'd4;

   // Jump condition.
   localparam logic [1:0] JUMP_NEVER  = 2'd0;
   localparam logic [1:0] JUMP_ROW0   = 2'd1;
   localparam logic [1:0] JUMP_ALWAYS = 2'd2;

   // Program entry points.
   localparam logic [3:0] PC_INIT   = 4'd0;
   localparam logic [3:0] PC_BYTE   = 4'd8;
   localparam logic [3:0] PC_CURSOR = 4'd10;
   localparam logic [3:0] PC_RIGHT  = 4'd14;

   typedef struct packed {
      logic [3:0] nib;
      logic [1:0] nib_sel;
      logic [1:0] wait_sel;
      logic       rs_from_item;
      logic [2:0] done_sel;
      logic [1:0] jump_sel;
      logic [3:0] target;
   } ctrl_word_type;

   function automatic ctrl_word_type cw(input logic [3:0] nib, input logic [1:0] nib_sel,
                                        input logic [1:0] wait_sel, input logic rs_item,
                                        input logic [2:0] done_sel,
                                        input logic [1:0] jump_sel,
                                        input logic [3:0] target);
      ctrl_word_type w;
      w.nib          = nib;
      w.nib_sel      = nib_sel;
      w.wait_sel     = wait_sel;
      w.rs_from_item = rs_item;
      w.done_sel     = done_sel;
      w.jump_sel     = jump_sel;
      w.target       = target;
      return w;
   endfunction

   // Microprogram. Init is all constants; bytes come from the item; cursor
   // placement sends home, an optional second-line command, then a loop of
   // cursor-right commands counted down by the column counter.
   function automatic ctrl_word_type rom(input logic [3:0] pc);
      ctrl_word_type w;
      case (pc)
         4'd0:  w = cw(4'h3, NIB_CONST, WAIT_POWER,   1'b0, DONE_NEVER,  JUMP_NEVER, PC_INIT);
         4'd1:  w = cw(4'h3, NIB_CONST, WAIT_INIT,    1'b0, DONE_NEVER,  JUMP_NEVER, PC_INIT);
         4'd2:  w = cw(4'h3, NIB_CONST, WAIT_INIT,    1'b0, DONE_NEVER,  JUMP_NEVER, PC_INIT);
         4'd3:  w = cw(4'h2, NIB_CONST, WAIT_INIT,    1'b0, DONE_NEVER,  JUMP_NEVER, PC_INIT);
         4'd4:  w = cw(4'h0, NIB_CONST, WAIT_COMMAND, 1'b0, DONE_NEVER,  JUMP_NEVER, PC_INIT);
         4'd5:  w = cw(4'hC, NIB_CONST, WAIT_NONE,    1'b0, DONE_NEVER,  JUMP_NEVER, PC_INIT);
         4'd6:  w = cw(4'h0, NIB_CONST, WAIT_COMMAND, 1'b0, DONE_NEVER,  JUMP_NEVER, PC_INIT);
         4'd7:  w = cw(4'h1, NIB_CONST, WAIT_NONE,    1'b0, DONE_ALWAYS, JUMP_NEVER, PC_INIT);
         4'd8:  w = cw(4'h0, NIB_HIGH,  WAIT_COMMAND, 1'b1, DONE_NEVER,  JUMP_NEVER, PC_INIT);
         4'd9:  w = cw(4'h0, NIB_LOW,   WAIT_NONE,    1'b1, DONE_ALWAYS, JUMP_NEVER, PC_INIT);
         4'd10: w = cw(4'h0, NIB_CONST, WAIT_COMMAND, 1'b0, DONE_NEVER,  JUMP_NEVER, PC_INIT);
         4'd11: w = cw(4'h2, NIB_CONST, WAIT_NONE,    1'b0, DONE_ROW0_COL0, JUMP_ROW0,
                       PC_RIGHT);
         4'd12: w = cw(4'hC, NIB_CONST, WAIT_COMMAND, 1'b0, DONE_NEVER,  JUMP_NEVER, PC_INIT);
         4'd13: w = cw(4'h0, NIB_CONST, WAIT_NONE,    1'b0, DONE_COL0,   JUMP_NEVER, PC_INIT);
         4'd14: w = cw(4'h1, NIB_CONST, WAIT_COMMAND, 1'b0, DONE_NEVER,  JUMP_NEVER, PC_INIT);
         4'd15: w = cw(4'h4, NIB_CONST, WAIT_NONE,    1'b0, DONE_CNT1,   JUMP_ALWAYS,
                       PC_RIGHT);
         default: w = cw(4'h0, NIB_CONST, WAIT_NONE,  1'b0, DONE_ALWAYS, JUMP_NEVER, PC_INIT);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/char_lcd_nibble_sequencer.sv
// Character LCD nibble sequencer: turns operations into 4-bit bus transfers.
// Uses lcdns_pkg for codes and the microprogram ROM.
//
// Usage:
// - req_* takes one operation per beat: init, data byte, command byte or
//   set cursor (row, col). req_ready is high whenever no operation is being
//   expanded; a pending result in the output register does not block it.
// - rsp_* gives one nibble transfer per beat with its wait in ms, register
//   select, a last mark on the final transfer of the operation and the
//   recorded cursor position.
// - csr_* writes the three wait registers; csr_ready is always high.
// An operation that yields k transfers keeps the input closed while the step
// counter walks the ROM, one microprogram step per transfer. k is 8 for init,
// 2 for a byte and 2 to 34 for a cursor placement; a rejected cursor placement
// yields nothing. The accept is registered in the busy flag and step counter
// first, and each transfer then passes through the output register.
// When the receiver stalls, the step counter holds and the output register
// keeps its beat. Reset empties the output register, stops the sequencer,
// loads the default waits and clears the recorded cursor to row 0, column 0.
`default_nettype none

module char_lcd_nibble_sequencer #(
   parameter int COLUMNS = lcdns_pkg::COLUMNS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_func,
   input  wire logic [7:0] req_byte_value,
   input  wire logic [7:0] req_row,
   input  wire logic [7:0] req_col,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [3:0]      rsp_nibble,
   output logic            rsp_reg_select,
   output logic [7:0]      rsp_wait_ms,
   output logic            rsp_last,
   output logic            rsp_cursor_row,
   output logic [3:0]      rsp_cursor_col,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_data
);
   import lcdns_pkg::*;

   localparam int COL_LIMIT = (COLUMNS < COL_FIELD_LIMIT) ? COLUMNS : COL_FIELD_LIMIT;
   localparam logic [8:0] COL_LIMIT_W = 9'(COL_LIMIT);

   logic [7:0] power_wait_ff, power_wait_in;
   logic [7:0] init_wait_ff, init_wait_in;
   logic [7:0] cmd_wait_ff, cmd_wait_in;
   logic       busy_ff, busy_in;
   logic [3:0] pc_ff, pc_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [7:0] byte_ff, byte_in;
   logic       rs_ff, rs_in;
   logic       cur_row_ff, cur_row_in;
   logic [3:0] cur_col_ff, cur_col_in;
   logic       out_valid_ff, out_valid_in;
   logic [3:0] out_nib_ff, out_nib_in;
   logic       out_rs_ff, out_rs_in;
   logic [7:0] out_wait_ff, out_wait_in;
   logic       out_last_ff, out_last_in;
   logic       out_row_ff, out_row_in;
   logic [3:0] out_col_ff, out_col_in;

   ctrl_word_type ctrl;
   logic req_fire, advance, done, jump, cursor_ok;

   assign req_ready = !busy_ff;
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign advance   = busy_ff && (!out_valid_ff || rsp_ready);
   assign ctrl      = rom(pc_ff);
   assign cursor_ok = (req_row <= 8'd1) && ({1'b0, req_col} < COL_LIMIT_W);

   always_comb begin
      case (ctrl.done_sel)
         DONE_NEVER:     done = 1'b0;
         DONE_ALWAYS:    done = 1'b1;
         DONE_ROW0_COL0: done = !cur_row_ff && (cnt_ff == 4'd0);
         DONE_COL0:      done = (cnt_ff == 4'd0);
         DONE_CNT1:      done = (cnt_ff == 4'd1);
         default:        done = 1'b1;
      endcase
      case (ctrl.jump_sel)
         JUMP_NEVER:  jump = 1'b0;
         JUMP_ROW0:   jump = !cur_row_ff;
         JUMP_ALWAYS: jump = 1'b1;
         default:     jump = 1'b0;
      endcase
   end

   always_comb begin
      power_wait_in = power_wait_ff;
      init_wait_in  = init_wait_ff;
      cmd_wait_in   = cmd_wait_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POWER_UP_WAIT:  power_wait_in = csr_data;
            CSR_INIT_STEP_WAIT: init_wait_in  = csr_data;
            CSR_COMMAND_WAIT:   cmd_wait_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      busy_in    = busy_ff;
      pc_in      = pc_ff;
      cnt_in     = cnt_ff;
      byte_in    = byte_ff;
      rs_in      = rs_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      if (req_fire) begin
         byte_in = req_byte_value;
         rs_in   = (req_func == FUNC_DATA);
         case (req_func)
            FUNC_INIT: begin
               busy_in = 1'b1;
               pc_in   = PC_INIT;
            end
            FUNC_DATA, FUNC_COMMAND: begin
               busy_in = 1'b1;
               pc_in   = PC_BYTE;
            end
            FUNC_SET_CURSOR: begin
               // An out-of-range position is dropped without any transfer.
               if (cursor_ok) begin
                  busy_in    = 1'b1;
                  pc_in      = PC_CURSOR;
                  cnt_in     = req_col[3:0];
                  cur_row_in = req_row[0];
                  cur_col_in = req_col[3:0];
               end
            end
            default: ;
         endcase
      end else if (advance) begin
         if (done) begin
            busy_in = 1'b0;
         end else if (jump) begin
            pc_in = ctrl.target;
         end else begin
            pc_in = pc_ff + 4'd1;
         end
         if (ctrl.done_sel == DONE_CNT1) begin
            cnt_in = cnt_ff - 4'd1;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_nib_in   = out_nib_ff;
      out_rs_in    = out_rs_ff;
      out_wait_in  = out_wait_ff;
      out_last_in  = out_last_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_last_in  = done;
         out_rs_in    = ctrl.rs_from_item && rs_ff;
         out_row_in   = cur_row_ff;
         out_col_in   = cur_col_ff;
         case (ctrl.nib_sel)
            NIB_HIGH: out_nib_in = byte_ff[7:4];
            NIB_LOW:  out_nib_in = byte_ff[3:0];
            default:  out_nib_in = ctrl.nib;
         endcase
         case (ctrl.wait_sel)
            WAIT_POWER:   out_wait_in = power_wait_ff;
            WAIT_INIT:    out_wait_in = init_wait_ff;
            WAIT_COMMAND: out_wait_in = cmd_wait_ff;
            default:      out_wait_in = 8'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_wait_ff <= POWER_UP_WAIT_RESET;
         init_wait_ff  <= INIT_STEP_WAIT_RESET;
         cmd_wait_ff   <= COMMAND_WAIT_RESET;
         busy_ff       <= 1'b0;
         pc_ff         <= PC_INIT;
         cnt_ff        <= 4'd0;
         cur_row_ff    <= 1'b0;
         cur_col_ff    <= 4'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         power_wait_ff <= power_wait_in;
         init_wait_ff  <= init_wait_in;
         cmd_wait_ff   <= cmd_wait_in;
         busy_ff       <= busy_in;
         pc_ff         <= pc_in;
         cnt_ff        <= cnt_in;
         cur_row_ff    <= cur_row_in;
         cur_col_ff    <= cur_col_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      rs_ff       <= rs_in;
      out_nib_ff  <= out_nib_in;
      out_rs_ff   <= out_rs_in;
      out_wait_ff <= out_wait_in;
      out_last_ff <= out_last_in;
      out_row_ff  <= out_row_in;
      out_col_ff  <= out_col_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_nibble     = out_nib_ff;
   assign rsp_reg_select = out_rs_ff;
   assign rsp_wait_ms    = out_wait_ff;
   assign rsp_last       = out_last_ff;
   // The position travels with each beat, since a new cursor placement can be
   // accepted while the last beat of the previous operation is still waiting.
   assign rsp_cursor_row = out_row_ff;
   assign rsp_cursor_col = out_col_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/lcdns_checker.sv
// Port-level checker for the character LCD nibble sequencer, with its bind.
// Depends on lcdns_pkg for the operation codes.
`default_nettype none

module lcdns_port_checks (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_func,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [3:0] rsp_nibble,
   input wire logic [7:0] rsp_wait_ms,
   input wire logic       rsp_last
);
   import lcdns_pkg::*;

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nibble) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // Every operation ends on a low nibble, which carries no wait.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_wait_ms == 8'd0)
      else $error("last transfer carries a wait");

   // Inside an operation the next transfer follows without a gap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside an operation");

   // Init, data and command always produce transfers, so the input closes.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func != FUNC_SET_CURSOR |=> !req_ready)
      else $error("input still open after a producing operation");

endmodule

bind char_lcd_nibble_sequencer lcdns_port_checks u_lcdns_port_checks (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_func    (req_func),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_nibble  (rsp_nibble),
   .rsp_wait_ms (rsp_wait_ms),
   .rsp_last    (rsp_last)
);

`default_nettype wire
